/* rtl/spmv_pkg.sv */
// ============================================================================
// spmv_pkg
// Shared types and constants for the sparse matrix-vector multiply block.
// ============================================================================
`default_nettype none

package spmv_pkg;

    // request function codes, carried on the slave tuser
    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_NZ    = 2'd1;
    localparam logic [1:0] FUNC_EMPTY = 2'd2;

    // configuration register indexes
    localparam logic [0:0] CFG_ROW_COUNT     = 1'b0;
    localparam logic [0:0] CFG_VECTOR_LENGTH = 1'b1;

    // field widths fixed by the stream format
    localparam int CFG_BITS   = 11;
    localparam int INDEX_BITS = 10;
    localparam int DATA_BITS  = 32;
    localparam int ACC_BITS   = 64;
    localparam int FRAC_BITS  = 16;

    // largest row count and its reset value
    localparam logic [CFG_BITS-1:0] ROW_LIMIT = 11'd1024;

    // result buffer depth and its count width
    localparam int OUT_DEPTH = 8;
    localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_BITS = $clog2(OUT_DEPTH + 1);

    // one result request
    typedef struct packed {
        logic [DATA_BITS-1:0]  y_value;
        logic [INDEX_BITS-1:0] row_index;
        logic                  final_row;
        logic                  column_error;
        logic                  saturated;
    } t_result;

endpackage

`default_nettype wire

/* rtl/spmv_ram.sv */
// ============================================================================
// spmv_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ============================================================================
`default_nettype none

module spmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/spmv_out_fifo.sv */
// ============================================================================
// spmv_out_fifo
// Small result buffer between the accumulator and the master stream.
// ============================================================================
`default_nettype none

module spmv_out_fifo (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  spmv_pkg::t_result  i_data,
    input  wire                i_pop,
    output logic               o_valid,
    output spmv_pkg::t_result  o_data
);

    spmv_pkg::t_result                     r_mem [spmv_pkg::OUT_DEPTH];
    logic [spmv_pkg::OUT_PTR_BITS-1:0]     r_wr, n_wr;
    logic [spmv_pkg::OUT_PTR_BITS-1:0]     r_rd, n_rd;
    logic [spmv_pkg::OUT_CNT_BITS-1:0]     r_cnt, n_cnt;
    logic                                  w_pop;

    assign w_pop = i_pop && (r_cnt != '0);

    // pointer and fill count update
    always_comb begin
        n_wr  = i_push ? r_wr + 1'b1 : r_wr;
        n_rd  = w_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt;
        if (i_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && w_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

endmodule

`default_nettype wire

/* rtl/csr_sparse_matrix_vector_multiply.sv */
// ============================================================================
// csr_sparse_matrix_vector_multiply
// y = A*x over a row-compressed nonzero stream, x held in an internal RAM.
// ============================================================================
// a row result passes the stage 1, 2 and 3 registers and the result buffer on its way to the master stream
// throughput: one request per cycle; one x RAM read and one multiply-accumulate each
// input stalls only when eight results are in flight or buffered and not taken
// reset: synchronous active low; clears pipeline, accumulator, row counter, buffer
// and sets both configuration registers to 1024; the x RAM is not cleared
`default_nettype none

module csr_sparse_matrix_vector_multiply #(
    parameter int MAX_ENTRIES = 1024,
    parameter int VALUE_BITS  = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration write port
    input  wire         i_cfg_we,
    input  wire  [0:0]  i_cfg_addr,
    input  wire  [10:0] i_cfg_wdata,
    // request stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [47:0] s_axis_tdata,   // index[9:0], value[41:10], zero[47:42]
    input  wire  [1:0]  s_axis_tuser,   // func[1:0]
    input  wire         s_axis_tlast,   // row_end
    // result stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata,   // y_value[31:0], row_index[41:32], zero[47:42]
    output logic [1:0]  m_axis_tuser,   // column_error[0], saturated[1]
    output logic        m_axis_tlast    // final_row
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int PW = 2 * VALUE_BITS;
    localparam logic [31:0] Y_HI = 32'((64'd1 << (VALUE_BITS - 1)) - 64'd1);
    localparam logic [31:0] Y_LO = ~Y_HI;

    // configuration registers
    logic [spmv_pkg::CFG_BITS-1:0] r_row_count;
    logic [spmv_pkg::CFG_BITS-1:0] r_vec_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= spmv_pkg::ROW_LIMIT;
            r_vec_len   <= spmv_pkg::ROW_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                spmv_pkg::CFG_ROW_COUNT:     r_row_count <= i_cfg_wdata;
                spmv_pkg::CFG_VECTOR_LENGTH: r_vec_len   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // request decode
    logic [1:0]                      w_func;
    logic [spmv_pkg::INDEX_BITS-1:0] w_idx;
    logic [VALUE_BITS-1:0]           w_val;
    logic                            w_acc;
    logic                            w_in_store;
    logic                            w_bad;
    logic                            w_is_nz;
    logic                            w_is_empty;
    logic                            w_gives_result;
    logic                            w_x_we;
    logic [AW-1:0]                   w_addr;

    assign w_func         = s_axis_tuser;
    assign w_idx          = s_axis_tdata[spmv_pkg::INDEX_BITS-1:0];
    assign w_val          = s_axis_tdata[spmv_pkg::INDEX_BITS +: VALUE_BITS];
    assign w_acc          = s_axis_tvalid && s_axis_tready;
    assign w_in_store     = (32'(w_idx) < 32'(MAX_ENTRIES));
    assign w_bad          = !w_in_store || ({1'b0, w_idx} >= r_vec_len);
    assign w_is_nz        = (w_func == spmv_pkg::FUNC_NZ);
    assign w_is_empty     = (w_func == spmv_pkg::FUNC_EMPTY);
    assign w_gives_result = w_is_empty || (w_is_nz && s_axis_tlast);
    assign w_x_we         = w_acc && (w_func == spmv_pkg::FUNC_LOAD) && w_in_store;
    assign w_addr         = AW'(w_idx);

    // x vector store
    logic [VALUE_BITS-1:0] w_x_q;

    spmv_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_ENTRIES)
    ) u_x_ram (
        .i_clk   (i_clk),
        .i_we    (w_x_we),
        .i_waddr (w_addr),
        .i_wdata (w_val),
        .i_raddr (w_addr),
        .o_rdata (w_x_q)
    );

    // stage 1: request fields beside the x read
    logic                  r1_valid;
    logic                  r1_nz;
    logic                  r1_close;
    logic                  r1_bad;
    logic [VALUE_BITS-1:0] r1_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= w_acc && (w_is_nz || w_is_empty);
        end
    end

    always_ff @(posedge i_clk) begin
        r1_nz    <= w_is_nz;
        r1_close <= w_gives_result;
        r1_bad   <= w_is_nz && w_bad;
        r1_val   <= w_val;
    end

    // stage 2: product of value and x entry
    logic signed [PW-1:0]                  w_mult;
    logic signed [spmv_pkg::ACC_BITS-1:0]  w_term;
    logic                                  r2_valid;
    logic                                  r2_close;
    logic                                  r2_bad;
    logic signed [spmv_pkg::ACC_BITS-1:0]  r2_prod;

    assign w_mult = $signed(r1_val) * $signed(w_x_q);
    assign w_term = (r1_nz && !r1_bad) ? spmv_pkg::ACC_BITS'(w_mult) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_close <= r1_close;
        r2_bad   <= r1_bad;
        r2_prod  <= w_term;
    end

    // stage 3: saturating accumulate and row close
    logic signed [spmv_pkg::ACC_BITS-1:0]  r_sum;
    logic signed [spmv_pkg::ACC_BITS-1:0]  w_raw;
    logic signed [spmv_pkg::ACC_BITS-1:0]  w_sum_new;
    logic                                  w_ovf;
    logic                                  r_err;
    logic [spmv_pkg::INDEX_BITS-1:0]       r_cur_row;
    logic [spmv_pkg::CFG_BITS-1:0]         w_rows_m1;
    logic                                  w_last;
    logic                                  w_close;

    assign w_raw     = r_sum + r2_prod;
    assign w_ovf     = (r_sum[63] == r2_prod[63]) && (w_raw[63] != r_sum[63]);
    assign w_sum_new = !w_ovf ? w_raw
                     : (r_sum[63] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}});
    assign w_close   = r2_valid && r2_close;

    // effective row count minus one, row count clamped to 1..1024
    always_comb begin
        if (r_row_count == '0) begin
            w_rows_m1 = '0;
        end else if (r_row_count > spmv_pkg::ROW_LIMIT) begin
            w_rows_m1 = spmv_pkg::ROW_LIMIT - 1'b1;
        end else begin
            w_rows_m1 = r_row_count - 1'b1;
        end
    end

    assign w_last = ({1'b0, r_cur_row} == w_rows_m1);

    logic                                  r3_valid;
    logic signed [spmv_pkg::ACC_BITS-1:0]  r3_sum;
    logic [spmv_pkg::INDEX_BITS-1:0]       r3_row;
    logic                                  r3_last;
    logic                                  r3_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_err     <= 1'b0;
            r_cur_row <= '0;
            r3_valid  <= 1'b0;
        end else begin
            r3_valid <= w_close;
            if (w_close) begin
                r_sum     <= '0;
                r_err     <= 1'b0;
                r_cur_row <= w_last ? '0 : r_cur_row + 1'b1;
            end else if (r2_valid) begin
                r_sum <= w_sum_new;
                r_err <= r_err || r2_bad;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r3_sum  <= w_sum_new;
        r3_row  <= r_cur_row;
        r3_last <= w_last;
        r3_err  <= r_err || r2_bad;
    end

    // stage 4: floor to Q16.16 and clip to the value range
    logic signed [spmv_pkg::ACC_BITS-1:0]  w_shift;
    logic                                  w_fits;
    logic                                  w_sat;
    logic signed [VALUE_BITS-1:0]          w_y;
    spmv_pkg::t_result                     w_res;

    assign w_shift = r3_sum >>> spmv_pkg::FRAC_BITS;
    assign w_fits  = (&w_shift[63:VALUE_BITS-1]) || !(|w_shift[63:VALUE_BITS-1]);
    assign w_sat   = !w_fits;
    assign w_y     = w_fits ? w_shift[VALUE_BITS-1:0]
                   : (w_shift[63] ? {1'b1, {(VALUE_BITS-1){1'b0}}}
                                  : {1'b0, {(VALUE_BITS-1){1'b1}}});

    always_comb begin
        w_res.y_value      = spmv_pkg::DATA_BITS'(w_y);
        w_res.row_index    = r3_row;
        w_res.final_row    = r3_last;
        w_res.column_error = r3_err;
        w_res.saturated    = w_sat;
    end

    // result buffer and credit count of results in flight or buffered
    spmv_pkg::t_result                 w_out;
    logic                              w_out_valid;
    logic                              w_out_acc;
    logic [spmv_pkg::OUT_CNT_BITS-1:0] r_pend;
    logic                              w_inc;

    spmv_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r3_valid),
        .i_data  (w_res),
        .i_pop   (m_axis_tready),
        .o_valid (w_out_valid),
        .o_data  (w_out)
    );

    assign w_out_acc = w_out_valid && m_axis_tready;
    assign w_inc     = w_acc && w_gives_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (w_inc && !w_out_acc) begin
            r_pend <= r_pend + 1'b1;
        end else if (!w_inc && w_out_acc) begin
            r_pend <= r_pend - 1'b1;
        end
    end

    assign s_axis_tready = (r_pend < spmv_pkg::OUT_CNT_BITS'(spmv_pkg::OUT_DEPTH));

    // master stream
    assign m_axis_tvalid = w_out_valid;
    assign m_axis_tdata  = {6'b0, w_out.row_index, w_out.y_value};
    assign m_axis_tuser  = {w_out.saturated, w_out.column_error};
    assign m_axis_tlast  = w_out.final_row;

`ifndef SYNTHESIS
    // credit count stays within the buffer depth
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= spmv_pkg::OUT_CNT_BITS'(spmv_pkg::OUT_DEPTH))
        else $error("result credit count above buffer depth");

    // a visible result is always covered by a credit
    a_out_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_pend != '0))
        else $error("result on the stream without a credit");

    // closing the final row sends the row counter back to zero
    a_row_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_close && w_last) |=> (r_cur_row == '0))
        else $error("row counter did not wrap after final row");

    // a row close leaves a clean accumulator behind
    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_close |=> (r_sum == '0) && !r_err)
        else $error("accumulator not cleared on row close");

    // a clipped result carries one of the range bounds
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1])
            |-> (m_axis_tdata[31:0] == Y_HI) || (m_axis_tdata[31:0] == Y_LO))
        else $error("saturated result not at a range bound");
`endif

endmodule

`default_nettype wire

/* test/spmv_row_checker.sv */
// ----------------------------------------------------------------------------
// spmv_row_checker
// Watches the request, result and configuration ports of the sparse
// matrix-vector multiply, predicts each row result and compares it in order.
// ----------------------------------------------------------------------------
module spmv_row_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [0:0]  i_cfg_addr,
    input  wire  [10:0] i_cfg_wdata,
    input  wire         i_req_valid,
    input  wire         i_req_ready,
    input  wire  [47:0] i_req_data,     // index[9:0], value[41:10], zero[47:42]
    input  wire  [1:0]  i_req_user,     // func[1:0]
    input  wire         i_req_last,
    input  wire         i_res_valid,
    input  wire         i_res_ready,
    input  wire  [47:0] i_res_data,     // y_value[31:0], row_index[41:32], zero[47:42]
    input  wire  [1:0]  i_res_user,     // column_error[0], saturated[1]
    input  wire         i_res_last,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;
    localparam logic signed [63:0] Y_MAX = 64'sd2147483647;
    localparam logic signed [63:0] Y_MIN = -64'sd2147483648;

    // shadow of the block state
    logic signed [spmv_pkg::DATA_BITS-1:0] x_mem [0:1023];
    logic signed [63:0]                    row_acc = '0;
    logic [9:0]                            row_ptr = '0;
    logic                                  row_bad_col = 1'b0;
    logic [spmv_pkg::CFG_BITS-1:0]         row_count_q = spmv_pkg::ROW_LIMIT;
    logic [spmv_pkg::CFG_BITS-1:0]         vec_len_q = spmv_pkg::ROW_LIMIT;
    spmv_pkg::t_result                     expected_rows_q [$];
    int                                    fail_count = 0;

    // 64-bit add that sticks at its bounds
    function automatic logic signed [63:0] add_clamped(input logic signed [63:0] a,
                                                       input logic signed [63:0] b);
        logic signed [64:0] s;
        s = a + b;
        if (s[64] != s[63])
            return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    // close the current row and queue its result
    task automatic close_row();
        logic signed [63:0] shifted;
        spmv_pkg::t_result  r;
        int                 rows;
        shifted = row_acc >>> spmv_pkg::FRAC_BITS;
        r.saturated = 1'b0;
        if (shifted > Y_MAX) begin
            r.y_value = Y_MAX[31:0];
            r.saturated = 1'b1;
        end else if (shifted < Y_MIN) begin
            r.y_value = Y_MIN[31:0];
            r.saturated = 1'b1;
        end else begin
            r.y_value = shifted[31:0];
        end
        rows = (row_count_q == 0) ? 1
             : ((row_count_q > spmv_pkg::ROW_LIMIT) ? 1024 : int'(row_count_q));
        r.row_index = row_ptr;
        r.final_row = (int'(row_ptr) == rows - 1);
        r.column_error = row_bad_col;
        expected_rows_q.push_back(r);
        row_ptr = r.final_row ? '0 : row_ptr + 10'd1;
        row_acc = '0;
        row_bad_col = 1'b0;
    endtask

    // work out the effect of one accepted request
    task automatic predict_request(input logic [1:0] func, input logic [9:0] idx,
                                   input logic signed [31:0] val, input logic row_end);
        logic signed [63:0] prod;
        case (func)
            spmv_pkg::FUNC_LOAD: x_mem[idx] = val;
            spmv_pkg::FUNC_NZ: begin
                if ({1'b0, idx} < vec_len_q) begin
                    prod = val * x_mem[idx];
                    row_acc = add_clamped(row_acc, prod);
                end else begin
                    row_bad_col = 1'b1;
                end
                if (row_end)
                    close_row();
            end
            spmv_pkg::FUNC_EMPTY: close_row();
            default: ;
        endcase
    endtask

    // sample all ports on the rising edge
    always @(posedge i_clk) begin : monitor
        spmv_pkg::t_result got;
        spmv_pkg::t_result want;
        if (!i_rst_n) begin
            row_acc = '0;
            row_ptr = '0;
            row_bad_col = 1'b0;
            row_count_q = spmv_pkg::ROW_LIMIT;
            vec_len_q = spmv_pkg::ROW_LIMIT;
            expected_rows_q.delete();
        end else begin
            // register writes
            if (i_cfg_we) begin
                if (i_cfg_addr == spmv_pkg::CFG_ROW_COUNT)
                    row_count_q = i_cfg_wdata;
                else
                    vec_len_q = i_cfg_wdata;
            end
            // compare a taken result with the oldest prediction
            if (i_res_valid && i_res_ready) begin
                got.y_value = i_res_data[31:0];
                got.row_index = i_res_data[41:32];
                got.final_row = i_res_last;
                got.column_error = i_res_user[0];
                got.saturated = i_res_user[1];
                if (expected_rows_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("unexpected row result: y=%h row=%0d final=%b colerr=%b sat=%b",
                                 got.y_value, got.row_index, got.final_row,
                                 got.column_error, got.saturated);
                end else begin
                    want = expected_rows_q.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display({"row result mismatch: expected y=%h row=%0d final=%b ",
                                      "colerr=%b sat=%b, got y=%h row=%0d final=%b ",
                                      "colerr=%b sat=%b"},
                                     want.y_value, want.row_index, want.final_row,
                                     want.column_error, want.saturated,
                                     got.y_value, got.row_index, got.final_row,
                                     got.column_error, got.saturated);
                    end
                end
            end
            // predict from an accepted request
            if (i_req_valid && i_req_ready)
                predict_request(i_req_user, i_req_data[9:0], i_req_data[41:10], i_req_last);
        end
        o_pending <= expected_rows_q.size();
        o_fail_count <= fail_count;
    end

endmodule

/* test/tb_csr_sparse_matrix_vector_multiply.sv */
// ----------------------------------------------------------------------------
// tb_csr_sparse_matrix_vector_multiply
// Drives x loads and row-ordered nonzeros through several register settings,
// with random idle bursts on both streams; the row checker scores the results.
// ----------------------------------------------------------------------------
module tb_csr_sparse_matrix_vector_multiply;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_addr = '0;
    logic [10:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [47:0] s_axis_tdata = '0;    // index[9:0], value[41:10], zero[47:42]
    logic [1:0]  s_axis_tuser = '0;    // func[1:0]
    logic        s_axis_tlast = 1'b0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [47:0] m_axis_tdata;         // y_value[31:0], row_index[41:32], zero[47:42]
    wire  [1:0]  m_axis_tuser;         // column_error[0], saturated[1]
    wire         m_axis_tlast;

    int fail_count;
    int pending;
    bit idle_on = 1'b1;
    int stall_left = 0;
    int quiet_cycles = 0;

    // stimulus bookkeeping
    bit x_loaded [0:1023];
    int loaded_cols [$];
    int row_count_set = 1024;
    int vec_len_set = 1024;
    int frame_row = 0;

    csr_sparse_matrix_vector_multiply dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    spmv_row_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_req_user   (s_axis_tuser),
        .i_req_last   (s_axis_tlast),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_res_user   (m_axis_tuser),
        .i_res_last   (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // result side back-pressure in random bursts
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 8);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog on cycles with no request or result taken
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_csr_sparse_matrix_vector_multiply NOT OK");
            $finish;
        end
    end

    function automatic int rows_eff(input int rc);
        return (rc == 0) ? 1 : ((rc > 1024) ? 1024 : rc);
    endfunction

    // mix of full range, small fixed point, extremes and mid-size values
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            2: begin
                case ($urandom_range(0, 4))
                    0: v = 32'h7fff_ffff;
                    1: v = 32'h8000_0000;
                    2: v = 32'h0000_0000;
                    3: v = 32'h0000_0001;
                    default: v = 32'hffff_ffff;
                endcase
            end
            default: v = $signed($urandom) >>> $urandom_range(8, 24);
        endcase
        return v;
    endfunction

    // column that is either loaded or beyond the vector length
    function automatic logic [9:0] pick_column();
        int c;
        if (vec_len_set < 1024 && $urandom_range(0, 9) == 0)
            return 10'($urandom_range(vec_len_set, 1023));
        c = loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
        for (int k = 0; k < 8; k++) begin
            if (c < vec_len_set)
                return 10'(c);
            c = loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
        end
        return 10'(c);
    endfunction

    // one request, with an optional idle burst ahead of it
    task automatic send_request(input logic [1:0] func, input logic [9:0] idx,
                                input logic [31:0] val, input logic row_end);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= func;
        s_axis_tdata <= {6'b0, val, idx};
        s_axis_tlast <= row_end;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (func == spmv_pkg::FUNC_LOAD && !x_loaded[idx]) begin
            x_loaded[idx] = 1'b1;
            loaded_cols.push_back(idx);
        end
        if ((func == spmv_pkg::FUNC_NZ && row_end) || func == spmv_pkg::FUNC_EMPTY)
            frame_row = (frame_row == rows_eff(row_count_set) - 1) ? 0 : (frame_row + 1) % 1024;
    endtask

    task automatic send_row(input int n);
        for (int k = 0; k < n; k++)
            send_request(spmv_pkg::FUNC_NZ, pick_column(), pick_value(), k == n - 1);
    endtask

    // hold requests until every row result has come, then let the pipe settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input int rc, input int vl);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= spmv_pkg::CFG_ROW_COUNT;
        i_cfg_wdata <= rc[10:0];
        @(posedge i_clk);
        i_cfg_addr <= spmv_pkg::CFG_VECTOR_LENGTH;
        i_cfg_wdata <= vl[10:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        row_count_set = rc;
        vec_len_set = vl;
    endtask

    // drain, close a nearly done frame, then apply a new setting
    task automatic next_setting(input int rc, input int vl);
        wait_drained();
        if (frame_row != 0 && rows_eff(row_count_set) - frame_row <= 64) begin
            while (frame_row != 0)
                send_request(spmv_pkg::FUNC_EMPTY, 10'($urandom_range(0, 1023)), pick_value(),
                             1'($urandom_range(0, 1)));
            wait_drained();
        end
        if (rows_eff(rc) <= frame_row)
            rc = frame_row + 1 + $urandom_range(0, 8);
        write_config(rc, vl);
    endtask

    // random rows with loads, empty rows and ignored requests mixed in
    task automatic run_phase(input int items, input bit idles, input bit hold_mid);
        int sent;
        int n;
        int lim;
        sent = 0;
        idle_on = idles;
        while (sent < items) begin
            if (hold_mid && sent >= items / 2) begin
                wait_drained();
                hold_mid = 1'b0;
            end
            case ($urandom_range(0, 15))
                0, 1: begin
                    lim = (vec_len_set < 1) ? 1 : ((vec_len_set > 1024) ? 1024 : vec_len_set);
                    n = $urandom_range(1, 4);
                    repeat (n)
                        send_request(spmv_pkg::FUNC_LOAD,
                                     10'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                                     : $urandom_range(0, lim - 1)),
                                     pick_value(), 1'($urandom_range(0, 1)));
                    sent += n;
                end
                2: begin
                    send_request(spmv_pkg::FUNC_EMPTY, 10'($urandom_range(0, 1023)),
                                 pick_value(), 1'($urandom_range(0, 1)));
                    sent++;
                end
                3: send_request(FUNC_UNUSED, 10'($urandom_range(0, 1023)), $urandom,
                                1'($urandom_range(0, 1)));
                4: begin
                    n = $urandom_range(7, 16);
                    send_row(n);
                    sent += n;
                end
                default: begin
                    n = $urandom_range(1, 6);
                    send_row(n);
                    sent += n;
                end
            endcase
        end
    endtask

    initial begin : stimulus
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows under the reset setting
        send_request(spmv_pkg::FUNC_LOAD, 10'd0, 32'h7fff_ffff, 1'b0);
        send_request(spmv_pkg::FUNC_LOAD, 10'd1023, 32'h8000_0000, 1'b1);
        send_request(spmv_pkg::FUNC_LOAD, 10'd5, 32'h0001_0000, 1'b0);
        send_request(spmv_pkg::FUNC_LOAD, 10'd10, 32'hffff_0000, 1'b0);
        // plain two-term row
        send_request(spmv_pkg::FUNC_NZ, 10'd5, 32'h0002_0000, 1'b0);
        send_request(spmv_pkg::FUNC_NZ, 10'd10, 32'h0000_8000, 1'b1);
        // empty row, row_end set but ignored
        send_request(spmv_pkg::FUNC_EMPTY, 10'd0, 32'h0000_0000, 1'b1);
        // unused function code
        send_request(FUNC_UNUSED, 10'd1023, 32'hffff_ffff, 1'b1);
        // output clips high
        send_request(spmv_pkg::FUNC_NZ, 10'd0, 32'h7fff_ffff, 1'b1);
        // accumulator runs past its upper bound
        repeat (3) send_request(spmv_pkg::FUNC_NZ, 10'd1023, 32'h8000_0000, 1'b0);
        send_request(spmv_pkg::FUNC_NZ, 10'd1023, 32'h8000_0000, 1'b1);
        // output clips low
        send_request(spmv_pkg::FUNC_NZ, 10'd1023, 32'h7fff_ffff, 1'b1);
        // smallest negative product, kept exact by the shift
        send_request(spmv_pkg::FUNC_NZ, 10'd5, 32'hffff_ffff, 1'b1);

        // short vector: columns past the end are flagged
        next_setting(10, 8);
        send_request(spmv_pkg::FUNC_NZ, 10'd9, 32'h0000_0001, 1'b0);
        send_request(spmv_pkg::FUNC_NZ, 10'd5, 32'h0001_0000, 1'b1);
        send_request(spmv_pkg::FUNC_NZ, 10'd1023, 32'h1234_5678, 1'b1);
        send_request(spmv_pkg::FUNC_EMPTY, 10'd1023, 32'hffff_ffff, 1'b0);

        // random phases over several settings
        next_setting(1, 1);
        run_phase(60, 1'b1, 1'b0);
        next_setting(0, 1024);
        run_phase(50, 1'b1, 1'b0);
        next_setting(4, 2047);
        run_phase(70, 1'b1, 1'b1);
        next_setting(12, 0);
        run_phase(40, 1'b0, 1'b0);
        next_setting(2047, 700);
        run_phase(80, 1'b1, 1'b0);
        next_setting(1024, 64);
        run_phase(60, 1'b1, 1'b0);
        next_setting($urandom_range(2, 40), $urandom_range(1, 1024));
        run_phase(90, 1'b1, 1'b0);
        // closing stretch without idles
        next_setting(3, 16);
        run_phase(100, 1'b0, 1'b0);

        wait_drained();
        if (fail_count == 0 && pending == 0)
            $display("tb_csr_sparse_matrix_vector_multiply OK");
        else
            $display("tb_csr_sparse_matrix_vector_multiply NOT OK");
        $finish;
    end

endmodule
